// ===== src/tlc_pkg.sv =====
// Shared types and constants for the two-layer tile map pixel compositor.
package tlc_pkg;

    localparam logic [2:0] FUNC_TILE     = 3'd0;
    localparam logic [2:0] FUNC_BG_MAP   = 3'd1;
    localparam logic [2:0] FUNC_CARD_MAP = 3'd2;
    localparam logic [2:0] FUNC_CARD_PAL = 3'd3;
    localparam logic [2:0] FUNC_BG_PAL   = 3'd4;
    localparam logic [2:0] FUNC_QUERY    = 3'd5;

    localparam int PAL_DEPTH      = 16;
    localparam int BYTES_PER_TILE = 32;
    localparam int MAP_IDX_W      = 12;
    localparam int HFLIP_BIT      = 10;
    localparam int VFLIP_BIT      = 11;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_CNT_W    = 3;

    typedef struct packed {
        logic [2:0]  func;
        logic [12:0] addr;
        logic [15:0] wdata;
        logic [7:0]  px;
        logic [7:0]  py;
    } in_t;

    typedef struct packed {
        logic [15:0] color;
        logic        card_opaque;
        logic        is_pixel;
    } out_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TILE,
        OP_BG_MAP,
        OP_CARD_MAP,
        OP_CARD_PAL,
        OP_BG_PAL,
        OP_QUERY
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [12:0]           addr;
        logic [15:0]           wdata;
        logic [MAP_IDX_W-1:0]  map_idx;
        logic                  in_map;
        logic [2:0]            fx;
        logic [2:0]            fy;
    } job_t;

    typedef struct packed {
        logic                   head_valid;
        logic [QUEUE_CNT_W-1:0] level;
    } queue_stat_t;

endpackage

// ===== src/tlc_queue.sv =====
// Small request queue between the front classifier and the back pipeline.
module tlc_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  tlc_pkg::job_t      push_job,
    output logic               full,
    input  logic               pop,
    output tlc_pkg::job_t      head_job,
    output tlc_pkg::queue_stat_t stat
);

    localparam int PTR_W = $clog2(tlc_pkg::QUEUE_DEPTH);

    tlc_pkg::job_t                   queue_reg [tlc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]                wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]                rd_ptr_reg, rd_ptr_next;
    logic [tlc_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                            do_push, do_pop;

    assign full     = (count_reg == tlc_pkg::QUEUE_CNT_W'(tlc_pkg::QUEUE_DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && (count_reg != '0);
    assign head_job = queue_reg[rd_ptr_reg];

    assign stat.head_valid = (count_reg != '0);
    assign stat.level      = count_reg;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            queue_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== src/tlc_front.sv =====
// Front end: accepts requests, range-checks writes, maps queries to tile positions.
module tlc_front #(
    parameter int TILE_COUNT       = 192,
    parameter int MAP_WIDTH_TILES  = 30,
    parameter int MAP_HEIGHT_TILES = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tlc_pkg::in_t         s_payload,
    input  logic                 pop,
    output tlc_pkg::job_t        head_job,
    output tlc_pkg::queue_stat_t stat
);

    localparam int SHEET_BYTES = TILE_COUNT * tlc_pkg::BYTES_PER_TILE;
    localparam int MAP_ENTRIES = MAP_WIDTH_TILES * MAP_HEIGHT_TILES;

    tlc_pkg::job_t job;
    logic          full;
    logic [4:0]    col, row;

    assign col = s_payload.px[7:3];
    assign row = s_payload.py[7:3];

    always_comb begin
        job.addr    = s_payload.addr;
        job.wdata   = s_payload.wdata;
        job.fx      = s_payload.px[2:0];
        job.fy      = s_payload.py[2:0];
        job.in_map  = (32'(col) < MAP_WIDTH_TILES) && (32'(row) < MAP_HEIGHT_TILES);
        job.map_idx = tlc_pkg::MAP_IDX_W'(32'(row) * MAP_WIDTH_TILES + 32'(col));
        job.op      = tlc_pkg::OP_NONE;
        unique case (s_payload.func)
            tlc_pkg::FUNC_TILE: begin
                if (32'(s_payload.addr) < SHEET_BYTES) job.op = tlc_pkg::OP_TILE;
            end
            tlc_pkg::FUNC_BG_MAP: begin
                if (32'(s_payload.addr) < MAP_ENTRIES) job.op = tlc_pkg::OP_BG_MAP;
            end
            tlc_pkg::FUNC_CARD_MAP: begin
                if (32'(s_payload.addr) < MAP_ENTRIES) job.op = tlc_pkg::OP_CARD_MAP;
            end
            tlc_pkg::FUNC_CARD_PAL: begin
                if (32'(s_payload.addr) < tlc_pkg::PAL_DEPTH) job.op = tlc_pkg::OP_CARD_PAL;
            end
            tlc_pkg::FUNC_BG_PAL: begin
                if (32'(s_payload.addr) < tlc_pkg::PAL_DEPTH) job.op = tlc_pkg::OP_BG_PAL;
            end
            tlc_pkg::FUNC_QUERY: begin
                job.op = tlc_pkg::OP_QUERY;
            end
            default: begin
                job.op = tlc_pkg::OP_NONE;
            end
        endcase
    end

    assign s_ready = !full;

    tlc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_valid),
        .push_job (job),
        .full     (full),
        .pop      (pop),
        .head_job (head_job),
        .stat     (stat)
    );

endmodule

// ===== src/tlc_back.sv =====
// Back end: map, tile sheet and palette stages with the result register.
module tlc_back #(
    parameter int TILE_COUNT       = 192,
    parameter int MAP_WIDTH_TILES  = 30,
    parameter int MAP_HEIGHT_TILES = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tlc_pkg::job_t        head_job,
    input  tlc_pkg::queue_stat_t stat,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tlc_pkg::out_t        m_payload
);

    localparam int SHEET_BYTES = TILE_COUNT * tlc_pkg::BYTES_PER_TILE;
    localparam int MAP_ENTRIES = MAP_WIDTH_TILES * MAP_HEIGHT_TILES;
    localparam int SAW = (SHEET_BYTES > 1) ? $clog2(SHEET_BYTES) : 1;
    localparam int MAW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

    logic [15:0] bg_map_mem   [MAP_ENTRIES];
    logic [15:0] card_map_mem [MAP_ENTRIES];
    logic [7:0]  sheet_mem    [SHEET_BYTES];
    logic [15:0] bg_pal_mem   [tlc_pkg::PAL_DEPTH];
    logic [15:0] card_pal_mem [tlc_pkg::PAL_DEPTH];

    logic advance;

    // stage 1: map entries
    logic          s1_valid_reg;
    tlc_pkg::job_t s1_job_reg;
    logic [15:0]   s1_bg_ent_reg, s1_card_ent_reg;

    // stage 2: tile bytes
    logic          s2_valid_reg;
    tlc_pkg::op_t  s2_op_reg;
    logic [3:0]    s2_addr_reg;
    logic [15:0]   s2_wdata_reg;
    logic          s2_bg_ok_reg, s2_card_ok_reg;
    logic          s2_bg_odd_reg, s2_card_odd_reg;
    logic [7:0]    s2_bg_byte_reg, s2_card_byte_reg;

    // stage 3: palette colors, result register
    logic          s3_valid_reg;
    logic          s3_query_reg;
    logic          s3_card_sel_reg;
    logic [15:0]   s3_bg_color_reg, s3_card_color_reg;

    logic [2:0]     bg_fx, bg_fy, card_fx, card_fy;
    logic           bg_ok, card_ok;
    logic [14:0]    bg_full_addr, card_full_addr;
    logic [SAW-1:0] bg_sheet_addr, card_sheet_addr;
    logic [3:0]     bg_idx, card_idx;

    assign advance = !s3_valid_reg || m_ready;
    assign pop     = advance && stat.head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= stat.head_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // map stage: writes and reads at the queue head
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (stat.head_valid && head_job.op == tlc_pkg::OP_BG_MAP) begin
                bg_map_mem[head_job.addr[MAW-1:0]] <= head_job.wdata;
            end
            if (stat.head_valid && head_job.op == tlc_pkg::OP_CARD_MAP) begin
                card_map_mem[head_job.addr[MAW-1:0]] <= head_job.wdata;
            end
            s1_bg_ent_reg   <= bg_map_mem[head_job.map_idx[MAW-1:0]];
            s1_card_ent_reg <= card_map_mem[head_job.map_idx[MAW-1:0]];
            s1_job_reg      <= head_job;
        end
    end

    always_comb begin
        bg_fx   = s1_job_reg.fx ^ {3{s1_bg_ent_reg[tlc_pkg::HFLIP_BIT]}};
        bg_fy   = s1_job_reg.fy ^ {3{s1_bg_ent_reg[tlc_pkg::VFLIP_BIT]}};
        card_fx = s1_job_reg.fx ^ {3{s1_card_ent_reg[tlc_pkg::HFLIP_BIT]}};
        card_fy = s1_job_reg.fy ^ {3{s1_card_ent_reg[tlc_pkg::VFLIP_BIT]}};
        bg_ok   = s1_job_reg.in_map && (32'(s1_bg_ent_reg[9:0]) < TILE_COUNT);
        card_ok = s1_job_reg.in_map && (32'(s1_card_ent_reg[9:0]) < TILE_COUNT);
        bg_full_addr    = {s1_bg_ent_reg[9:0], bg_fy, bg_fx[2:1]};
        card_full_addr  = {s1_card_ent_reg[9:0], card_fy, card_fx[2:1]};
        bg_sheet_addr   = bg_ok ? bg_full_addr[SAW-1:0] : '0;
        card_sheet_addr = card_ok ? card_full_addr[SAW-1:0] : '0;
    end

    // tile sheet stage: one write port, two read ports
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (s1_valid_reg && s1_job_reg.op == tlc_pkg::OP_TILE) begin
                sheet_mem[SAW'(s1_job_reg.addr)] <= s1_job_reg.wdata[7:0];
            end
            s2_bg_byte_reg   <= sheet_mem[bg_sheet_addr];
            s2_card_byte_reg <= sheet_mem[card_sheet_addr];
            s2_op_reg        <= s1_job_reg.op;
            s2_addr_reg      <= s1_job_reg.addr[3:0];
            s2_wdata_reg     <= s1_job_reg.wdata;
            s2_bg_ok_reg     <= bg_ok;
            s2_card_ok_reg   <= card_ok;
            s2_bg_odd_reg    <= bg_fx[0];
            s2_card_odd_reg  <= card_fx[0];
        end
    end

    always_comb begin
        bg_idx   = '0;
        card_idx = '0;
        if (s2_bg_ok_reg) begin
            bg_idx = s2_bg_odd_reg ? s2_bg_byte_reg[7:4] : s2_bg_byte_reg[3:0];
        end
        if (s2_card_ok_reg) begin
            card_idx = s2_card_odd_reg ? s2_card_byte_reg[7:4] : s2_card_byte_reg[3:0];
        end
    end

    // palette stage
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (s2_valid_reg && s2_op_reg == tlc_pkg::OP_CARD_PAL) begin
                card_pal_mem[s2_addr_reg] <= s2_wdata_reg;
            end
            if (s2_valid_reg && s2_op_reg == tlc_pkg::OP_BG_PAL) begin
                bg_pal_mem[s2_addr_reg] <= s2_wdata_reg;
            end
            s3_card_color_reg <= card_pal_mem[card_idx];
            s3_bg_color_reg   <= bg_pal_mem[bg_idx];
            s3_card_sel_reg   <= (card_idx != '0);
            s3_query_reg      <= (s2_op_reg == tlc_pkg::OP_QUERY);
        end
    end

    always_comb begin
        m_payload.is_pixel    = s3_query_reg;
        m_payload.card_opaque = s3_query_reg && s3_card_sel_reg;
        m_payload.color       = '0;
        if (s3_query_reg) begin
            m_payload.color = s3_card_sel_reg ? s3_card_color_reg : s3_bg_color_reg;
        end
    end

    assign m_valid = s3_valid_reg;

endmodule

// ===== src/two_layer_tilemap_pixel_compositor.sv =====
// Top level of the two-layer tile map pixel compositor.
//
// Requests enter on s_valid/s_ready/s_payload: tile byte, background map,
// card map and palette writes, and pixel queries. Each request gives exactly
// one result on m_valid/m_ready/m_payload, in order: a write acknowledge
// (is_pixel 0, color 0) or a composited pixel color.
// A request goes into a 4-entry queue, then through three registered stages:
// map read, tile sheet read (two read ports, one per layer), palette read.
// One request per cycle is sustained while no result waits with m_ready low.
// Writes are performed at the stage that owns the store, so a query always
// sees every earlier write.
// Reset clears the queue and stage valid bits only; stores hold whatever
// they had until written. While a result waits with m_ready low the three
// stages hold and the queue keeps taking requests until it is full, then
// s_ready drops.
module two_layer_tilemap_pixel_compositor #(
    parameter int TILE_COUNT       = 192,
    parameter int MAP_WIDTH_TILES  = 30,
    parameter int MAP_HEIGHT_TILES = 20
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tlc_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output tlc_pkg::out_t m_payload
);

    tlc_pkg::job_t        head_job;
    tlc_pkg::queue_stat_t stat;
    logic                 pop;

    tlc_front #(
        .TILE_COUNT       (TILE_COUNT),
        .MAP_WIDTH_TILES  (MAP_WIDTH_TILES),
        .MAP_HEIGHT_TILES (MAP_HEIGHT_TILES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .pop       (pop),
        .head_job  (head_job),
        .stat      (stat)
    );

    tlc_back #(
        .TILE_COUNT       (TILE_COUNT),
        .MAP_WIDTH_TILES  (MAP_WIDTH_TILES),
        .MAP_HEIGHT_TILES (MAP_HEIGHT_TILES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_job  (head_job),
        .stat      (stat),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    a_ack_is_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.is_pixel |-> m_payload.color == '0 && !m_payload.card_opaque)
        else $error("write acknowledge carries color data");

    a_stall_holds_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> stat.level >= $past(stat.level))
        else $error("queue drained while output stalled");

    a_no_pop_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !pop)
        else $error("request popped while output stalled");

    a_ready_tracks_level: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> stat.level == tlc_pkg::QUEUE_CNT_W'(tlc_pkg::QUEUE_DEPTH))
        else $error("input stalled with room in queue");

endmodule
